// File: sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tle_pkg.sv
package tle_pkg;

    // Received character codes
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_EOF     = 8'd4;
    localparam logic [7:0] CH_ERASE   = 8'd127;
    localparam logic [7:0] CH_KILL    = 8'd21;
    localparam logic [7:0] CH_WERASE  = 8'd23;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TILDE   = 8'd126;

    // Configuration
    localparam int         WRAP_W     = 7;
    localparam logic [6:0] WRAP_RESET = 7'd40;

    // Result action codes
    typedef enum logic [2:0] {
        ACT_ECHO     = 3'd0,
        ACT_ERASE    = 3'd1,
        ACT_CLEAR    = 3'd2,
        ACT_WRAP     = 3'd3,
        ACT_BEEP     = 3'd4,
        ACT_LINE_END = 3'd5,
        ACT_EOF      = 3'd6
    } t_action;

endpackage

// File: sv/tle_line_mem.sv
// Line store: one write port, one read port, registered read data.
module tle_line_mem #(
    parameter int DEPTH = 64,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [7:0]       i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [7:0]       o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/terminal_line_editor_top.sv
// Terminal line editor. Takes one received character per input transaction and
// answers with zero or more result transactions (echo, erase column, clear line,
// wrap newline, beep, line end, end of input); o_last marks the final result of
// each character, and backspace or word erase on an empty line yields none.
// The block handles one character at a time and holds o_stall high while it
// works: it accepts in S_IDLE, decodes in S_DECODE, then emits its results
// from S_EMIT, waiting while the output is stalled. Word erase scans the
// stored line back through the line store's single registered read port,
// reading each column in S_WE_RD and testing it in S_WE_CMP, then emits its
// erase results. The wrap column register (i_cfg_wr_data, reset 40) is
// capped at MAX_COLUMNS when compared; a value of zero wraps every
// printable character.
module terminal_line_editor_top #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_char,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_action,
    output logic [7:0] o_echo_char,
    output logic       o_last
);

`include "assert_macros.svh"

    localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LEN_W = $clog2(MAX_COLUMNS + 1);
    localparam int CMP_W = (LEN_W > tle_pkg::WRAP_W) ? LEN_W : tle_pkg::WRAP_W;
    localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_ZERO = '0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WE_RD,
        S_WE_CMP,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_cnt;
    logic [7:0]         r_char;
    logic [6:0]         r_wrap;
    tle_pkg::t_action   r_act;
    logic               r_then_echo;
    logic               r_word;
    logic               r_out_valid;
    logic [2:0]         r_out_action;
    logic [7:0]         r_out_char;
    logic               r_out_last;

    logic               in_accept;
    logic               slot_free;
    logic               is_print;
    logic               line_full;
    logic [CMP_W-1:0]   wrap_eff;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [IDX_W-1:0]   mem_raddr;
    logic [LEN_W-1:0]   len_dec;
    logic [7:0]         mem_rdata;
    logic               rd_space;
    logic               scan_go;
    logic               out_mid;

    // handshake
    assign in_accept = i_valid && !o_stall;
    assign slot_free = !r_out_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE);

    // character class and wrap test
    assign is_print  = (r_char >= tle_pkg::CH_SPACE) && (r_char <= tle_pkg::CH_TILDE);
    assign wrap_eff  = (CMP_W'(r_wrap) > CMP_W'(MAX_COLUMNS)) ? CMP_W'(MAX_COLUMNS)
                                                              : CMP_W'(r_wrap);
    assign line_full = CMP_W'(r_len) >= wrap_eff;

    // line store access
    assign len_dec   = r_len - LEN_ONE;
    assign mem_we    = (r_state == S_DECODE) && is_print;
    assign mem_waddr = line_full ? '0 : r_len[IDX_W-1:0];
    assign mem_raddr = len_dec[IDX_W-1:0];

    tle_line_mem #(
        .DEPTH (MAX_COLUMNS)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_char),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // word erase: skip trailing spaces, then the word
    assign rd_space = (mem_rdata == tle_pkg::CH_SPACE);
    assign scan_go  = r_word ? !rd_space : 1'b1;

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= LEN_ZERO;
            r_wrap      <= tle_pkg::WRAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_wrap <= i_cfg_wr_data;
            end

            // output valid: load in S_EMIT, clear once taken
            if (r_state == S_EMIT && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_char  <= i_rx_char;
                        r_state <= S_DECODE;
                    end
                end

                S_DECODE: begin
                    r_then_echo <= is_print && line_full;
                    r_cnt       <= (r_char == tle_pkg::CH_WERASE) ? LEN_ZERO : LEN_ONE;
                    r_word      <= 1'b0;
                    priority if (r_char == tle_pkg::CH_NEWLINE) begin
                        r_len   <= LEN_ZERO;
                        r_act   <= tle_pkg::ACT_LINE_END;
                        r_state <= S_EMIT;
                    end else if (r_char == tle_pkg::CH_EOF && r_len == LEN_ZERO) begin
                        r_act   <= tle_pkg::ACT_EOF;
                        r_state <= S_EMIT;
                    end else if (r_char == tle_pkg::CH_ERASE) begin
                        if (r_len != LEN_ZERO) begin
                            r_len   <= len_dec;
                            r_act   <= tle_pkg::ACT_ERASE;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (r_char == tle_pkg::CH_KILL) begin
                        r_len   <= LEN_ZERO;
                        r_act   <= tle_pkg::ACT_CLEAR;
                        r_state <= S_EMIT;
                    end else if (r_char == tle_pkg::CH_WERASE) begin
                        r_state <= (r_len == LEN_ZERO) ? S_IDLE : S_WE_RD;
                    end else if (is_print) begin
                        if (line_full) begin
                            r_len <= LEN_ONE;
                            r_act <= tle_pkg::ACT_WRAP;
                        end else begin
                            r_len <= r_len + LEN_ONE;
                            r_act <= tle_pkg::ACT_ECHO;
                        end
                        r_state <= S_EMIT;
                    end else begin
                        r_act   <= tle_pkg::ACT_BEEP;
                        r_state <= S_EMIT;
                    end
                end

                // read of the column before r_len is in flight
                S_WE_RD: begin
                    r_state <= S_WE_CMP;
                end

                S_WE_CMP: begin
                    r_act <= tle_pkg::ACT_ERASE;
                    if (!r_word && !rd_space) begin
                        r_word <= 1'b1;
                    end
                    if (scan_go) begin
                        r_len   <= len_dec;
                        r_cnt   <= r_cnt + LEN_ONE;
                        r_state <= (r_len == LEN_ONE) ? S_EMIT : S_WE_RD;
                    end else begin
                        r_state <= (r_cnt == LEN_ZERO) ? S_IDLE : S_EMIT;
                    end
                end

                S_EMIT: begin
                    if (slot_free) begin
                        r_out_action <= r_act;
                        r_out_char   <= (r_act == tle_pkg::ACT_ECHO) ? r_char : 8'd0;
                        r_out_last   <= (r_cnt == LEN_ONE) && !r_then_echo;
                        if (r_cnt != LEN_ONE) begin
                            r_cnt <= r_cnt - LEN_ONE;
                        end else if (r_then_echo) begin
                            r_act       <= tle_pkg::ACT_ECHO;
                            r_then_echo <= 1'b0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_action    = r_out_action;
    assign o_echo_char = r_out_char;
    assign o_last      = r_out_last;

    // checks
    assign out_mid = r_out_valid && !r_out_last;

    `ASSERT_IMPLY(a_len_range, i_clk, i_rst_n, 1'b1, r_len <= LEN_W'(MAX_COLUMNS), "len range")
    `ASSERT_IMPLY(a_run_busy, i_clk, i_rst_n, out_mid, r_state == S_EMIT, "run cut")
    `ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, in_accept, r_state == S_DECODE, "no decode")
    `ASSERT_IMPLY(a_wr_range, i_clk, i_rst_n, mem_we, int'(mem_waddr) < MAX_COLUMNS, "waddr")

endmodule

// File: bench/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS = 64;
    // Cycles allowed for a character that produces no result to finish
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        tle_pkg::t_action act;
        logic [7:0]       ch;
        logic             last;
    } t_edit_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [6:0] i_cfg_wr_data = '0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_char = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [2:0] o_action;
    logic [7:0] o_echo_char;
    logic       o_last;

    terminal_line_editor_top #(
        .MAX_COLUMNS(MAX_COLS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_char    (i_rx_char),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_action     (o_action),
        .o_echo_char  (o_echo_char),
        .o_last       (o_last)
    );

    // Shadow copy of the editor state
    logic [7:0]   line_mem [MAX_COLS];
    int           line_len;
    logic [6:0]   wrap_cfg;
    t_edit_result pending_edits[$];
    int           err_count = 0;

    // Idle percentages for the current phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    task automatic push_result(input tle_pkg::t_action act, input logic [7:0] ch);
        t_edit_result r;
        r.act  = act;
        r.ch   = ch;
        r.last = 1'b0;
        pending_edits.push_back(r);
    endtask

    // Apply one accepted character to the shadow state and queue its results
    task automatic apply_char(input logic [7:0] c);
        int           eff_wrap;
        int           n;
        t_edit_result r;
        eff_wrap = (wrap_cfg > MAX_COLS) ? MAX_COLS : int'(wrap_cfg);
        n = pending_edits.size();
        if (c == tle_pkg::CH_NEWLINE) begin
            line_len = 0;
            push_result(tle_pkg::ACT_LINE_END, 8'd0);
        end else if (c == tle_pkg::CH_EOF && line_len == 0) begin
            push_result(tle_pkg::ACT_EOF, 8'd0);
        end else if (c == tle_pkg::CH_ERASE) begin
            if (line_len > 0) begin
                line_len--;
                push_result(tle_pkg::ACT_ERASE, 8'd0);
            end
        end else if (c == tle_pkg::CH_KILL) begin
            line_len = 0;
            push_result(tle_pkg::ACT_CLEAR, 8'd0);
        end else if (c == tle_pkg::CH_WERASE) begin
            // trailing spaces first, then the word itself
            while (line_len > 0 && line_mem[line_len-1] == tle_pkg::CH_SPACE) begin
                line_len--;
                push_result(tle_pkg::ACT_ERASE, 8'd0);
            end
            while (line_len > 0 && line_mem[line_len-1] != tle_pkg::CH_SPACE) begin
                line_len--;
                push_result(tle_pkg::ACT_ERASE, 8'd0);
            end
        end else if (c >= tle_pkg::CH_SPACE && c <= tle_pkg::CH_TILDE) begin
            if (line_len >= eff_wrap) begin
                line_len = 0;
                push_result(tle_pkg::ACT_WRAP, 8'd0);
            end
            line_mem[line_len] = c;
            line_len++;
            push_result(tle_pkg::ACT_ECHO, c);
        end else begin
            push_result(tle_pkg::ACT_BEEP, 8'd0);
        end
        // mark the final result of this character
        if (pending_edits.size() > n) begin
            r = pending_edits.pop_back();
            r.last = 1'b1;
            pending_edits.push_back(r);
        end
    endtask

    // Offer one character and wait for the transaction; valid stays high after it
    task automatic send_char(input logic [7:0] c);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid   <= 1'b1;
        i_rx_char <= c;
        do @(posedge i_clk); while (o_stall);
        apply_char(c);
    endtask

    // Write the wrap column once the block has drained
    task automatic set_wrap(input logic [6:0] value);
        i_valid <= 1'b0;
        while (pending_edits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        wrap_cfg = value;
    endtask

    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return ($urandom_range(3) == 0) ? tle_pkg::CH_SPACE : 8'($urandom_range(33, 126));
        else if (r < 65)
            return tle_pkg::CH_ERASE;
        else if (r < 72)
            return tle_pkg::CH_WERASE;
        else if (r < 75)
            return tle_pkg::CH_KILL;
        else if (r < 80)
            return tle_pkg::CH_NEWLINE;
        else if (r < 84)
            return tle_pkg::CH_EOF;
        else
            return 8'($urandom_range(255));
    endfunction

    // Editing keys on an empty line
    task automatic test_empty_line_cases();
        send_char(tle_pkg::CH_ERASE);
        send_char(tle_pkg::CH_WERASE);
        send_char(tle_pkg::CH_EOF);
    endtask

    // Word erase over trailing spaces, Ctrl+D mid-line, backspace, kill, newline
    task automatic test_edit_keys();
        send_char("a");
        send_char(tle_pkg::CH_SPACE);
        send_char("b");
        send_char(tle_pkg::CH_SPACE);
        send_char(tle_pkg::CH_SPACE);
        send_char(tle_pkg::CH_WERASE);
        send_char(tle_pkg::CH_EOF);
        send_char(tle_pkg::CH_ERASE);
        send_char(tle_pkg::CH_KILL);
        send_char("q");
        send_char(tle_pkg::CH_NEWLINE);
    endtask

    // Byte extremes and printable range edges
    task automatic test_odd_bytes();
        send_char(8'd0);
        send_char(8'd255);
        send_char(8'd128);
        send_char(8'd31);
        send_char(tle_pkg::CH_SPACE);
        send_char(tle_pkg::CH_TILDE);
    endtask

    // Wrap column of one, zero and above the line size
    task automatic test_wrap_extremes();
        set_wrap(7'd1);
        send_char("x");
        send_char("y");
        set_wrap(7'd0);
        send_char("z");
        set_wrap(7'd127);
        send_char(tle_pkg::CH_NEWLINE);
    endtask

    // Fill a whole line with one word at the saturated wrap column, then erase it
    task automatic test_full_line();
        set_wrap(7'd127);
        send_char(tle_pkg::CH_NEWLINE);
        repeat (MAX_COLS) send_char(8'($urandom_range(33, 126)));
        send_char(tle_pkg::CH_WERASE);
    endtask

    task automatic test_random(input int count, input logic [6:0] wrap,
                               input int idle_pct, input int stall_pct);
        set_wrap(wrap);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_char(random_char());
    endtask

    // Result checker
    always @(posedge i_clk) begin : check_results
        t_edit_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_edits.size() == 0) begin
                $display("%0t: unexpected result: action %0d char %0d last %0d",
                         $time, o_action, o_echo_char, o_last);
                err_count++;
            end else begin
                want = pending_edits.pop_front();
                if (o_action !== want.act) begin
                    $display("%0t: action expected %0d actual %0d",
                             $time, want.act, o_action);
                    err_count++;
                end
                if (o_echo_char !== want.ch) begin
                    $display("%0t: echo_char expected %0d actual %0d",
                             $time, want.ch, o_echo_char);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %0d actual %0d",
                             $time, want.last, o_last);
                    err_count++;
                end
            end
        end
    end

    initial begin
        line_len = 0;
        wrap_cfg = tle_pkg::WRAP_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_line_cases();
        test_edit_keys();
        test_odd_bytes();
        test_wrap_extremes();
        recv_stall_pct = 67;
        test_full_line();
        test_random(22, 7'd8, 0, 0);
        test_random(22, 7'd40, 67, 0);
        test_random(22, 7'd127, 0, 67);
        test_random(22, 7'd3, 38, 38);

        // drain
        i_valid <= 1'b0;
        while (pending_edits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
